// ===== design/segint_pkg.sv =====
package segint_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 8;
  localparam int OUT_BITS   = COORD_BITS + FRAC_BITS;
  // coordinate difference
  localparam int DIFF_BITS  = COORD_BITS + 1;
  // product of two differences
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  // cross-product denominator and line parameter
  localparam int DEN_BITS   = 2 * COORD_BITS + 3;
  // crossing point numerators
  localparam int NUM_BITS   = 3 * COORD_BITS + 4;
  // front end pipeline depth and total latency from accept to strobe
  localparam int FRONT_STAGES = 7;
  localparam int LATENCY      = FRONT_STAGES + OUT_BITS + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [OUT_BITS-1:0]   fix_t;

  typedef struct packed {
    coord_t a_start_x;
    coord_t a_start_y;
    coord_t a_end_x;
    coord_t a_end_y;
    coord_t b_start_x;
    coord_t b_start_y;
    coord_t b_end_x;
    coord_t b_end_y;
  } item_t;

  typedef struct packed {
    logic hit;
    logic parallel;
    fix_t cross_x;
    fix_t cross_y;
  } result_t;

  // one lane of the restoring divider
  typedef struct packed {
    logic                neg;
    logic                ovf;
    logic [DEN_BITS-1:0] rem;
    logic [OUT_BITS-1:0] bits;
    logic [OUT_BITS-1:0] quo;
  } lane_t;

  // record passed from cell to cell
  typedef struct packed {
    logic                valid;
    logic                hit;
    logic                par;
    logic [DEN_BITS-1:0] den;
    lane_t               x;
    lane_t               y;
  } stage_t;

endpackage

// ===== design/segint_front.sv =====
module segint_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  segint_pkg::item_t   item,
  output segint_pkg::stage_t  head
);

  localparam int CW = segint_pkg::COORD_BITS;
  localparam int FW = segint_pkg::FRAC_BITS;
  localparam int OW = segint_pkg::OUT_BITS;
  localparam int DW = segint_pkg::DIFF_BITS;
  localparam int PW = segint_pkg::PROD_BITS;
  localparam int EW = segint_pkg::DEN_BITS;
  localparam int NW = segint_pkg::NUM_BITS;
  localparam int BW = CW + EW;
  localparam int MW = NW + FW;

  logic [segint_pkg::FRONT_STAGES-1:1] v;

  // stage 1: captured item
  segint_pkg::item_t s1;

  // stage 2: differences and first products
  segint_pkg::item_t s2;
  logic signed [DW-1:0] s2_dx1, s2_dy1, s2_dx2;
  logic                 s2_va, s2_vb;
  logic signed [PW-1:0] s2_pda, s2_pdb, s2_pta, s2_ptb;
  logic signed [PW-1:0] s2_nxa, s2_nya1, s2_nya2, s2_nxb, s2_nyb1, s2_nyb2;

  logic signed [DW-1:0] dx1_c, dy1_c, dx2_c, dy2_c, dbx_c, dby_c;
  always_comb begin
    dx1_c = DW'(s1.a_end_x) - DW'(s1.a_start_x);
    dy1_c = DW'(s1.a_end_y) - DW'(s1.a_start_y);
    dx2_c = DW'(s1.b_end_x) - DW'(s1.b_start_x);
    dy2_c = DW'(s1.b_end_y) - DW'(s1.b_start_y);
    dbx_c = DW'(s1.b_start_x) - DW'(s1.a_start_x);
    dby_c = DW'(s1.b_start_y) - DW'(s1.a_start_y);
  end

  // stage 3: denominator, line parameter, vertical-case numerators
  segint_pkg::item_t s3;
  logic signed [DW-1:0] s3_dx1, s3_dy1, s3_dx2;
  logic                 s3_va, s3_vb;
  logic signed [EW-1:0] s3_den, s3_t;
  logic signed [NW-1:0] s3_nxa, s3_nya, s3_nxb, s3_nyb;

  // stage 4: general-case products
  segint_pkg::item_t s4;
  logic signed [DW-1:0] s4_dx1, s4_dx2;
  logic                 s4_va, s4_vb;
  logic signed [EW-1:0] s4_den;
  logic signed [NW-1:0] s4_nxa, s4_nya, s4_nxb, s4_nyb;
  logic signed [BW-1:0] s4_m1, s4_m3;
  logic signed [DW+EW-1:0] s4_m2, s4_m4;

  // stage 5: chosen case, non-negative denominator
  segint_pkg::item_t s5;
  logic                 s5_par;
  logic signed [NW-1:0] s5_nx, s5_ny;
  logic signed [EW-1:0] s5_dm;

  logic signed [NW-1:0] gnx_c, gny_c, nx_c, ny_c;
  logic signed [EW-1:0] d_c;
  logic                 par_c;
  always_comb begin
    gnx_c = NW'(s4_m1) + NW'(s4_m2);
    gny_c = NW'(s4_m3) + NW'(s4_m4);
    par_c = (s4_va && s4_vb) || (!s4_va && !s4_vb && s4_den == '0);
    priority if (s4_va) begin
      d_c = EW'(s4_dx2); nx_c = s4_nxa; ny_c = s4_nya;
    end else if (s4_vb) begin
      d_c = EW'(s4_dx1); nx_c = s4_nxb; ny_c = s4_nyb;
    end else begin
      d_c = s4_den; nx_c = gnx_c; ny_c = gny_c;
    end
  end

  // stage 6: bounding box edges scaled by the denominator
  logic                 s6_par;
  logic signed [NW-1:0] s6_nx, s6_ny;
  logic signed [EW-1:0] s6_dm;
  logic signed [BW-1:0] s6_axl, s6_axh, s6_ayl, s6_ayh, s6_bxl, s6_bxh, s6_byl, s6_byh;

  function automatic segint_pkg::coord_t cmin(segint_pkg::coord_t p, segint_pkg::coord_t q);
    return (p < q) ? p : q;
  endfunction
  function automatic segint_pkg::coord_t cmax(segint_pkg::coord_t p, segint_pkg::coord_t q);
    return (p < q) ? q : p;
  endfunction

  // stage 7: hit test and divider setup
  function automatic segint_pkg::lane_t lane_init(logic signed [NW-1:0] n,
                                                 logic signed [EW-1:0] dm);
    segint_pkg::lane_t l;
    logic [NW-1:0]      mag;
    logic [MW-1:0]      m;
    l.neg  = n[NW-1];
    mag    = l.neg ? NW'(-n) : NW'(n);
    m      = {mag, {FW{1'b0}}};
    l.ovf  = m[MW-1:OW] >= (MW-OW)'($unsigned(dm));
    l.rem  = l.ovf ? '0 : EW'(m[MW-1:OW]);
    l.bits = m[OW-1:0];
    l.quo  = '0;
    return l;
  endfunction

  logic hit_c;
  always_comb begin
    hit_c = (s6_nx >= NW'(s6_axl)) && (s6_nx <= NW'(s6_axh)) &&
            (s6_ny >= NW'(s6_ayl)) && (s6_ny <= NW'(s6_ayh)) &&
            (s6_nx >= NW'(s6_bxl)) && (s6_nx <= NW'(s6_bxh)) &&
            (s6_ny >= NW'(s6_byl)) && (s6_ny <= NW'(s6_byh));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v          <= '0;
      head.valid <= 1'b0;
    end else begin
      v          <= {v[segint_pkg::FRONT_STAGES-2:1], start && !busy};
      head.valid <= v[segint_pkg::FRONT_STAGES-1];
    end

    s1 <= item;

    s2      <= s1;
    s2_dx1  <= dx1_c;
    s2_dy1  <= dy1_c;
    s2_dx2  <= dx2_c;
    s2_va   <= dx1_c == '0;
    s2_vb   <= dx2_c == '0;
    s2_pda  <= dx1_c * dy2_c;
    s2_pdb  <= dy1_c * dx2_c;
    s2_pta  <= dbx_c * dy2_c;
    s2_ptb  <= dby_c * dx2_c;
    s2_nxa  <= s1.a_start_x * dx2_c;
    s2_nya1 <= s1.b_start_y * dx2_c;
    s2_nya2 <= dy2_c * (-dbx_c);
    s2_nxb  <= s1.b_start_x * dx1_c;
    s2_nyb1 <= s1.a_start_y * dx1_c;
    s2_nyb2 <= dy1_c * dbx_c;

    s3     <= s2;
    s3_dx1 <= s2_dx1;
    s3_dy1 <= s2_dy1;
    s3_dx2 <= s2_dx2;
    s3_va  <= s2_va;
    s3_vb  <= s2_vb;
    s3_den <= EW'(s2_pda) - EW'(s2_pdb);
    s3_t   <= EW'(s2_pta) - EW'(s2_ptb);
    s3_nxa <= NW'(s2_nxa);
    s3_nya <= NW'(s2_nya1) + NW'(s2_nya2);
    s3_nxb <= NW'(s2_nxb);
    s3_nyb <= NW'(s2_nyb1) + NW'(s2_nyb2);

    s4     <= s3;
    s4_dx1 <= s3_dx1;
    s4_dx2 <= s3_dx2;
    s4_va  <= s3_va;
    s4_vb  <= s3_vb;
    s4_den <= s3_den;
    s4_nxa <= s3_nxa;
    s4_nya <= s3_nya;
    s4_nxb <= s3_nxb;
    s4_nyb <= s3_nyb;
    s4_m1  <= s3.a_start_x * s3_den;
    s4_m2  <= s3_dx1 * s3_t;
    s4_m3  <= s3.a_start_y * s3_den;
    s4_m4  <= s3_dy1 * s3_t;

    s5     <= s4;
    s5_par <= par_c;
    s5_nx  <= d_c[EW-1] ? -nx_c : nx_c;
    s5_ny  <= d_c[EW-1] ? -ny_c : ny_c;
    s5_dm  <= d_c[EW-1] ? -d_c : d_c;

    s6_par <= s5_par;
    s6_nx  <= s5_nx;
    s6_ny  <= s5_ny;
    s6_dm  <= s5_dm;
    s6_axl <= cmin(s5.a_start_x, s5.a_end_x) * s5_dm;
    s6_axh <= cmax(s5.a_start_x, s5.a_end_x) * s5_dm;
    s6_ayl <= cmin(s5.a_start_y, s5.a_end_y) * s5_dm;
    s6_ayh <= cmax(s5.a_start_y, s5.a_end_y) * s5_dm;
    s6_bxl <= cmin(s5.b_start_x, s5.b_end_x) * s5_dm;
    s6_bxh <= cmax(s5.b_start_x, s5.b_end_x) * s5_dm;
    s6_byl <= cmin(s5.b_start_y, s5.b_end_y) * s5_dm;
    s6_byh <= cmax(s5.b_start_y, s5.b_end_y) * s5_dm;

    head.hit <= hit_c && !s6_par;
    head.par <= s6_par;
    head.den <= $unsigned(s6_dm);
    head.x   <= lane_init(s6_nx, s6_dm);
    head.y   <= lane_init(s6_ny, s6_dm);
  end

endmodule

// ===== design/segint_cell.sv =====
module segint_cell (
  input  logic               clk,
  input  logic               rst,
  input  segint_pkg::stage_t prev,
  output segint_pkg::stage_t next
);

  localparam int EW = segint_pkg::DEN_BITS;
  localparam int OW = segint_pkg::OUT_BITS;

  // one restoring quotient bit
  function automatic segint_pkg::lane_t step(segint_pkg::lane_t l, logic [EW-1:0] den);
    segint_pkg::lane_t r;
    logic [EW:0]       rr;
    logic              ge;
    rr     = {l.rem, l.bits[OW-1]};
    ge     = rr >= {1'b0, den};
    r      = l;
    r.rem  = ge ? EW'(rr - {1'b0, den}) : EW'(rr);
    r.bits = {l.bits[OW-2:0], 1'b0};
    r.quo  = {l.quo[OW-2:0], ge};
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      next.valid <= 1'b0;
    end else begin
      next.valid <= prev.valid;
    end
    next.hit <= prev.hit;
    next.par <= prev.par;
    next.den <= prev.den;
    next.x   <= step(prev.x, prev.den);
    next.y   <= step(prev.y, prev.den);
  end

endmodule

// ===== design/segment_intersection.sv =====
// segment_intersection: crossing point of the lines through two segments
//
// input channel: item holds both segments' endpoints; a transaction happens
//   at a rising edge with start high and busy low
// busy is high only during reset; otherwise a new transaction may be
//   started every cycle
// output channel: done is high for exactly one cycle with result valid;
//   the receiver takes it at that edge and cannot stall the block
// pipeline: from the accepting edge to the edge that takes the result, an
//   item passes 7 front end stages for products, case selection and the
//   bounding box test, one divider cell per output bit, and the output register
// throughput: one transaction per cycle; results leave in accept order
// reset (synchronous) flushes every transaction in flight, no result of
//   those ever appears
module segment_intersection (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  segint_pkg::item_t    item,
  output logic                 done,
  output segint_pkg::result_t  result
);

  localparam int OW = segint_pkg::OUT_BITS;

  // chain of divider cells, one quotient bit per cell
  segint_pkg::stage_t chain [OW+1];

  assign busy = rst;

  segint_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .item  (item),
    .head  (chain[0])
  );

  for (genvar i = 0; i < OW; i++) begin : g_cell
    segint_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .prev (chain[i]),
      .next (chain[i+1])
    );
  end

  // floor rounding and saturation of one lane
  function automatic segint_pkg::fix_t finish(segint_pkg::lane_t l);
    logic [OW:0]      qq;
    segint_pkg::fix_t f;
    qq = {1'b0, l.quo} + (OW+1)'(l.rem != '0);
    if (!l.neg) begin
      // positive: anything at or above the top bit saturates
      f = (l.ovf || l.quo[OW-1]) ? {1'b0, {(OW-1){1'b1}}} : l.quo;
    end else if (l.ovf || qq > {2'b01, {(OW-1){1'b0}}}) begin
      f = {1'b1, {(OW-1){1'b0}}};
    end else begin
      f = OW'(-qq);
    end
    return f;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= chain[OW].valid;
    end
  end

  always_ff @(posedge clk) begin
    result.hit      <= chain[OW].hit;
    result.parallel <= chain[OW].par;
    // parallel lines have no point: report zero
    result.cross_x  <= chain[OW].par ? '0 : finish(chain[OW].x);
    result.cross_y  <= chain[OW].par ? '0 : finish(chain[OW].y);
  end

endmodule

// ===== design/segint_checker.sv =====
module segint_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input segint_pkg::result_t result
);

  localparam int LAT = segint_pkg::LATENCY;

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT done)
    else $error("result missing after fixed latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a matching transaction");

  a_parallel_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.parallel |-> !result.hit && result.cross_x == '0 &&
                               result.cross_y == '0)
    else $error("parallel result carries a point");

  a_busy_reset: assert property (@(posedge clk)
    busy == rst)
    else $error("busy outside reset");

endmodule

bind segment_intersection segint_checker u_segint_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
